FILE: design/tpd_pkg.sv
// Shared types and constants for the takeoff phase detector.
package tpd_pkg;

  typedef enum logic [1:0] {
    PH_GROUNDED = 2'd0,
    PH_PENDING  = 2'd1,
    PH_AIRBORNE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    REG_FREEZE_THR   = 3'd0,
    REG_AIRBORNE_THR = 3'd1,
    REG_ABORT_THR    = 3'd2,
    REG_MIN_CLB_ALT  = 3'd3,
    REG_MIN_CLB_RATE = 3'd4,
    REG_ABORT_ALT    = 3'd5,
    REG_ABORT_RATE   = 3'd6,
    REG_MOTION_CONF  = 3'd7
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef struct packed {
    logic [11:0]        freeze_thr;
    logic [11:0]        airborne_thr;
    logic [11:0]        abort_thr;
    logic signed [23:0] min_climb_altitude_mm;
    logic signed [15:0] min_climb_rate_mms;
    logic [22:0]        abort_max_altitude_mm;
    logic [14:0]        abort_max_rate_mms;
    logic [15:0]        motion_confirm_ms;
  } cfg_t;

  typedef struct packed {
    logic               running;
    logic [11:0]        throttle;
    logic               altitude_valid;
    logic signed [23:0] altitude_mm;
    logic signed [15:0] climb_rate_mms;
    logic [31:0]        time_ms;
  } item_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] motion_start_time;
    logic [31:0] abort_start_time;
    logic [31:0] airborne_time;
    logic        motion_timing;
    logic        abort_timing;
  } state_t;

  typedef struct packed {
    phase_t phase;
    logic   ground_constraint;
    logic   baro_deweight;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:             PH_GROUNDED,
    motion_start_time: 32'd0,
    abort_start_time:  32'd0,
    airborne_time:     32'd0,
    motion_timing:     1'b0,
    abort_timing:      1'b0
  };

endpackage

FILE: design/tpd_cfg.sv
// Configuration register file for the takeoff phase detector.
module tpd_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tpd_pkg::cfg_t                cfg
);
  import tpd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_FREEZE_THR:   cfg_nxt.freeze_thr            = cfg_wdata[11:0];
        REG_AIRBORNE_THR: cfg_nxt.airborne_thr          = cfg_wdata[11:0];
        REG_ABORT_THR:    cfg_nxt.abort_thr             = cfg_wdata[11:0];
        REG_MIN_CLB_ALT:  cfg_nxt.min_climb_altitude_mm = $signed(cfg_wdata[23:0]);
        REG_MIN_CLB_RATE: cfg_nxt.min_climb_rate_mms    = $signed(cfg_wdata[15:0]);
        REG_ABORT_ALT:    cfg_nxt.abort_max_altitude_mm = cfg_wdata[22:0];
        REG_ABORT_RATE:   cfg_nxt.abort_max_rate_mms    = cfg_wdata[14:0];
        REG_MOTION_CONF:  cfg_nxt.motion_confirm_ms     = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.freeze_thr            <= 12'd1150;
      cfg_r.airborne_thr          <= 12'd1300;
      cfg_r.abort_thr             <= 12'd1100;
      cfg_r.min_climb_altitude_mm <= 24'sd200;
      cfg_r.min_climb_rate_mms    <= 16'sd100;
      cfg_r.abort_max_altitude_mm <= 23'd100;
      cfg_r.abort_max_rate_mms    <= 15'd100;
      cfg_r.motion_confirm_ms     <= 16'd300;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/tpd_step.sv
// Phase transition and result logic for one tick.
module tpd_step #(
  parameter int unsigned ABORT_CONFIRM_MS = 500,
  parameter int unsigned BARO_RECOVERY_MS = 1000
) (
  input  tpd_pkg::cfg_t    cfg,
  input  tpd_pkg::item_t   item,
  input  tpd_pkg::state_t  st,
  output tpd_pkg::state_t  st_nxt,
  output tpd_pkg::result_t res
);
  import tpd_pkg::*;

  localparam logic [31:0] ABORT_LIM = 32'(ABORT_CONFIRM_MS);
  localparam logic [31:0] BARO_LIM  = 32'(BARO_RECOVERY_MS);

  logic [23:0] alt_abs;
  logic [15:0] rate_abs;
  logic        up;
  logic        still;
  logic        thrust_up;
  logic        low_still;
  logic [31:0] mot_start;
  logic [31:0] abt_start;
  logic        mot_done;
  logic        abt_done;
  logic [31:0] air_elapsed;

  assign alt_abs  = item.altitude_mm[23] ? 24'(-item.altitude_mm) : item.altitude_mm;
  assign rate_abs = item.climb_rate_mms[15] ? 16'(-item.climb_rate_mms) : item.climb_rate_mms;

  assign up = item.altitude_valid &&
              ($signed(item.altitude_mm) >= $signed(cfg.min_climb_altitude_mm)) &&
              ($signed(item.climb_rate_mms) >= $signed(cfg.min_climb_rate_mms));
  assign still = item.altitude_valid &&
                 (alt_abs <= {1'b0, cfg.abort_max_altitude_mm}) &&
                 (rate_abs <= {1'b0, cfg.abort_max_rate_mms});

  assign thrust_up = (item.throttle >= cfg.airborne_thr) && up;
  assign low_still = (item.throttle < cfg.abort_thr) && still;

  assign mot_start = st.motion_timing ? st.motion_start_time : item.time_ms;
  assign abt_start = st.abort_timing ? st.abort_start_time : item.time_ms;
  assign mot_done  = (32'(item.time_ms - mot_start)) >= {16'd0, cfg.motion_confirm_ms};
  assign abt_done  = (32'(item.time_ms - abt_start)) >= ABORT_LIM;

  // next state
  always_comb begin
    st_nxt = st;
    if (!item.running) begin
      st_nxt = STATE_RESET;
    end else begin
      case (st.phase)
        PH_AIRBORNE: ;
        PH_PENDING: begin
          if (thrust_up) begin
            st_nxt.motion_start_time = mot_start;
            st_nxt.motion_timing     = 1'b1;
          end else begin
            st_nxt.motion_timing = 1'b0;
          end
          if (thrust_up && mot_done) begin
            st_nxt.phase         = PH_AIRBORNE;
            st_nxt.airborne_time = item.time_ms;
            st_nxt.abort_timing  = 1'b0;
          end else if (low_still) begin
            if (abt_done) begin
              st_nxt = STATE_RESET;
            end else begin
              st_nxt.abort_start_time = abt_start;
              st_nxt.abort_timing     = 1'b1;
            end
          end else begin
            st_nxt.abort_timing = 1'b0;
          end
        end
        default: begin
          st_nxt.phase = PH_GROUNDED;
          if (item.throttle >= cfg.freeze_thr) begin
            st_nxt.phase         = PH_PENDING;
            st_nxt.motion_timing = 1'b0;
            st_nxt.abort_timing  = 1'b0;
          end
        end
      endcase
    end
  end

  assign air_elapsed = 32'(item.time_ms - st_nxt.airborne_time);

  // result
  always_comb begin
    res.phase             = st_nxt.phase;
    res.ground_constraint = 1'b0;
    res.baro_deweight     = 1'b0;
    case (st_nxt.phase)
      PH_GROUNDED: res.ground_constraint = 1'b1;
      PH_PENDING:  res.baro_deweight = 1'b1;
      PH_AIRBORNE: res.baro_deweight = air_elapsed < BARO_LIM;
      default: ;
    endcase
  end

endmodule

FILE: design/takeoff_phase_detector.sv
// Takeoff phase detector top level: input register, step logic, result register.
//
//   channel | signals                                   | direction
//   in      | in_valid/in_ready + six item fields       | in
//   out     | out_valid/out_ready + phase, flags        | out
//   cfg     | cfg_we, cfg_index, cfg_wdata              | in
//
// One item per cycle while out_ready holds; out_valid rises as the result register loads.
// Phase state advances when an item moves from the input register to the result register.
// Synchronous active-low reset: phase grounded, timers cleared, config to defaults.
// A stalled out side holds the result register; the input register still takes one item.
module takeoff_phase_detector #(
  parameter int unsigned ABORT_CONFIRM_MS = 500,
  parameter int unsigned BARO_RECOVERY_MS = 1000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_running,
  input  logic [11:0] in_throttle,
  input  logic        in_altitude_valid,
  input  logic signed [23:0] in_altitude_mm,
  input  logic signed [15:0] in_climb_rate_mms,
  input  logic [31:0] in_time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_phase,
  output logic        out_ground_constraint,
  output logic        out_baro_deweight,
  input  logic        cfg_we,
  input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tpd_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_valid_r;
  state_t  st_r;
  state_t  st_nxt;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    advance;

  tpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tpd_step #(
    .ABORT_CONFIRM_MS (ABORT_CONFIRM_MS),
    .BARO_RECOVERY_MS (BARO_RECOVERY_MS)
  ) u_step (
    .cfg    (cfg),
    .item   (item_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign advance  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.running        <= in_running;
      item_r.throttle       <= in_throttle;
      item_r.altitude_valid <= in_altitude_valid;
      item_r.altitude_mm    <= in_altitude_mm;
      item_r.climb_rate_mms <= in_climb_rate_mms;
      item_r.time_ms        <= in_time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_phase             = res_r.phase;
  assign out_ground_constraint = res_r.ground_constraint;
  assign out_baro_deweight     = res_r.baro_deweight;

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> item_valid_r && out_valid_r && !out_ready)
    else $error("input blocked without a stalled result");

  a_airborne_latch: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item_r.running && st_r.phase == PH_AIRBORNE |=> st_r.phase == PH_AIRBORNE)
    else $error("airborne left while running");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !item_r.running |=>
      st_r.phase == PH_GROUNDED && !st_r.motion_timing && !st_r.abort_timing)
    else $error("stop did not clear phase state");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid && res_r.phase == st_r.phase)
    else $error("result phase differs from state");

  a_ground_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ground_constraint == (res_r.phase == PH_GROUNDED))
    else $error("ground constraint inconsistent with phase");

endmodule

FILE: tb/takeoff_phase_detector_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the takeoff phase detector: random flights against a phase predictor.
module takeoff_phase_detector_tb;
  import tpd_pkg::*;

  localparam int unsigned ABORT_MS    = 500;
  localparam int unsigned RECOVERY_MS = 1000;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          PHASE_ITEMS = 118;

  localparam cfg_t CFG_DEFAULT = '{
    freeze_thr: 1150, airborne_thr: 1300, abort_thr: 1100,
    min_climb_altitude_mm: 200, min_climb_rate_mms: 100,
    abort_max_altitude_mm: 100, abort_max_rate_mms: 100, motion_confirm_ms: 300
  };
  localparam cfg_t CFG_FLOOR = '{
    freeze_thr: 0, airborne_thr: 0, abort_thr: 4095,
    min_climb_altitude_mm: -8388608, min_climb_rate_mms: -32768,
    abort_max_altitude_mm: 8388607, abort_max_rate_mms: 32767, motion_confirm_ms: 0
  };
  localparam cfg_t CFG_OVERLAP = '{
    freeze_thr: 1000, airborne_thr: 1000, abort_thr: 2000,
    min_climb_altitude_mm: -50, min_climb_rate_mms: -50,
    abort_max_altitude_mm: 100, abort_max_rate_mms: 100, motion_confirm_ms: 800
  };
  localparam cfg_t CFG_CEILING = '{
    freeze_thr: 4095, airborne_thr: 4095, abort_thr: 0,
    min_climb_altitude_mm: 8388607, min_climb_rate_mms: 32767,
    abort_max_altitude_mm: 0, abort_max_rate_mms: 0, motion_confirm_ms: 65535
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_running = 1'b0;
  logic [11:0] in_throttle = '0;
  logic in_altitude_valid = 1'b0;
  logic signed [23:0] in_altitude_mm = '0;
  logic signed [15:0] in_climb_rate_mms = '0;
  logic [31:0] in_time_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_phase;
  logic out_ground_constraint;
  logic out_baro_deweight;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  item_t tick_q[$];
  result_t phase_exp_q[$];
  cfg_t mdl_cfg;
  state_t trk;
  logic [31:0] gen_now;
  int g_frz, g_air, g_abt, g_alt, g_rate, g_salt, g_srate, g_conf;
  int in_gap, rdy_gap, errors, cycles, gen_count;
  bit quiet;

  takeoff_phase_detector DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic result_t predict_phase(input item_t it);
    result_t r;
    int alt, rate, abs_alt, abs_rate;
    bit up, still, launched;
    logic [31:0] dt;
    alt = $signed(it.altitude_mm);
    rate = $signed(it.climb_rate_mms);
    abs_alt = (alt < 0) ? -alt : alt;
    abs_rate = (rate < 0) ? -rate : rate;
    if (!it.running) begin
      trk = STATE_RESET;
    end else if (trk.phase == PH_PENDING) begin
      up = it.altitude_valid && alt >= int'($signed(mdl_cfg.min_climb_altitude_mm)) &&
           rate >= int'($signed(mdl_cfg.min_climb_rate_mms));
      still = it.altitude_valid && abs_alt <= int'(mdl_cfg.abort_max_altitude_mm) &&
              abs_rate <= int'(mdl_cfg.abort_max_rate_mms);
      launched = 1'b0;
      if (it.throttle >= mdl_cfg.airborne_thr && up) begin
        if (!trk.motion_timing) begin
          trk.motion_start_time = it.time_ms;
          trk.motion_timing = 1'b1;
        end
        dt = it.time_ms - trk.motion_start_time;
        if (dt >= {16'd0, mdl_cfg.motion_confirm_ms}) begin
          trk.phase = PH_AIRBORNE;
          trk.airborne_time = it.time_ms;
          trk.abort_timing = 1'b0;
          launched = 1'b1;
        end
      end else begin
        trk.motion_timing = 1'b0;
      end
      // motion check wins when both hold in one tick
      if (!launched) begin
        if (it.throttle < mdl_cfg.abort_thr && still) begin
          if (!trk.abort_timing) begin
            trk.abort_start_time = it.time_ms;
            trk.abort_timing = 1'b1;
          end
          dt = it.time_ms - trk.abort_start_time;
          if (dt >= ABORT_MS) trk = STATE_RESET;
        end else begin
          trk.abort_timing = 1'b0;
        end
      end
    end else if (trk.phase != PH_AIRBORNE) begin
      trk.phase = PH_GROUNDED;
      if (it.throttle >= mdl_cfg.freeze_thr) begin
        trk.phase = PH_PENDING;
        trk.motion_timing = 1'b0;
        trk.abort_timing = 1'b0;
      end
    end
    dt = it.time_ms - trk.airborne_time;
    r.phase = trk.phase;
    r.ground_constraint = (trk.phase == PH_GROUNDED);
    r.baro_deweight = (trk.phase == PH_PENDING) ||
                      (trk.phase == PH_AIRBORNE && dt < RECOVERY_MS);
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    item_t seen;
    result_t want;
    if (!rst_n) begin
      trk = STATE_RESET;
      mdl_cfg = CFG_DEFAULT;
      phase_exp_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          REG_FREEZE_THR:   mdl_cfg.freeze_thr            = cfg_wdata[11:0];
          REG_AIRBORNE_THR: mdl_cfg.airborne_thr          = cfg_wdata[11:0];
          REG_ABORT_THR:    mdl_cfg.abort_thr             = cfg_wdata[11:0];
          REG_MIN_CLB_ALT:  mdl_cfg.min_climb_altitude_mm = cfg_wdata[23:0];
          REG_MIN_CLB_RATE: mdl_cfg.min_climb_rate_mms    = cfg_wdata[15:0];
          REG_ABORT_ALT:    mdl_cfg.abort_max_altitude_mm = cfg_wdata[22:0];
          REG_ABORT_RATE:   mdl_cfg.abort_max_rate_mms    = cfg_wdata[14:0];
          REG_MOTION_CONF:  mdl_cfg.motion_confirm_ms     = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (phase_exp_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual phase %0d", $time,
                   out_phase);
          errors++;
        end else begin
          want = phase_exp_q.pop_front();
          check_field("phase", want.phase, out_phase);
          check_field("ground_constraint", want.ground_constraint, out_ground_constraint);
          check_field("baro_deweight", want.baro_deweight, out_baro_deweight);
        end
      end
      if (in_valid && in_ready) begin
        seen.running = in_running;
        seen.throttle = in_throttle;
        seen.altitude_valid = in_altitude_valid;
        seen.altitude_mm = in_altitude_mm;
        seen.climb_rate_mms = in_climb_rate_mms;
        seen.time_ms = in_time_ms;
        phase_exp_q.push_back(predict_phase(seen));
      end
    end
  end

  always @(posedge clk) begin : drive_ticks
    item_t nx;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        in_valid <= 1'b0;
        in_gap = $urandom_range(0, 7);
      end else if (tick_q.size() != 0) begin
        nx = tick_q.pop_front();
        in_running <= nx.running;
        in_throttle <= nx.throttle;
        in_altitude_valid <= nx.altitude_valid;
        in_altitude_mm <= nx.altitude_mm;
        in_climb_rate_mms <= nx.climb_rate_mms;
        in_time_ms <= nx.time_ms;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
      rdy_gap = 0;
    end else if (rdy_gap > 0) begin
      out_ready <= 1'b0;
      rdy_gap--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rdy_gap = $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick(int lo, int hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(hi - lo));
    endcase
  endfunction

  function automatic void load_gen(cfg_t c);
    g_frz = c.freeze_thr;
    g_air = c.airborne_thr;
    g_abt = c.abort_thr;
    g_alt = $signed(c.min_climb_altitude_mm);
    g_rate = $signed(c.min_climb_rate_mms);
    g_salt = c.abort_max_altitude_mm;
    g_srate = c.abort_max_rate_mms;
    g_conf = c.motion_confirm_ms;
  endfunction

  function automatic void push_tick(bit run, int thr, bit val, int alt, int rate,
                                    logic [31:0] t);
    item_t it;
    it.running = run;
    it.throttle = thr[11:0];
    it.altitude_valid = val;
    it.altitude_mm = alt[23:0];
    it.climb_rate_mms = rate[15:0];
    it.time_ms = t;
    tick_q.push_back(it);
    gen_count++;
  endfunction

  function automatic void add_noise();
    logic [31:0] t;
    if ($urandom_range(0, 1)) begin
      gen_now += $urandom_range(0, 600);
      t = gen_now;
    end else begin
      t = $urandom;
    end
    push_tick($urandom_range(0, 9) != 0, $urandom_range(0, 4095), $urandom_range(0, 1),
              $urandom, $urandom, t);
  endfunction

  // one condition just misses its threshold
  function automatic void push_miss(bit abort_side);
    int thr, alt, rate;
    bit val;
    val = 1'b1;
    if (!abort_side) begin
      thr = pick(g_air, 4095);
      alt = pick(g_alt, 8388607);
      rate = pick(g_rate, 32767);
      case ($urandom_range(0, 3))
        0: val = 1'b0;
        1: if (g_air > 0) thr = g_air - 1; else val = 1'b0;
        2: if (g_alt > -8388608) alt = g_alt - 1; else val = 1'b0;
        default: if (g_rate > -32768) rate = g_rate - 1; else val = 1'b0;
      endcase
    end else begin
      thr = pick(0, g_abt - 1);
      alt = pick(-g_salt, g_salt);
      rate = pick(-g_srate, g_srate);
      case ($urandom_range(0, 3))
        0: val = 1'b0;
        1: thr = g_abt;
        2: if (g_salt < 8388607) alt = $urandom_range(0, 1) ? g_salt + 1 : -g_salt - 1;
           else val = 1'b0;
        default: if (g_srate < 32767) rate = $urandom_range(0, 1) ? g_srate + 1 : -g_srate - 1;
                 else val = 1'b0;
      endcase
    end
    gen_now += $urandom_range(1, 50);
    push_tick(1'b1, thr, val, alt, rate, gen_now);
  endfunction

  function automatic void add_flight();
    int acc, target, n, step, steps;
    steps = g_conf / 4 + 30;
    if ($urandom_range(0, 4) != 0) begin
      gen_now += $urandom_range(1, 100);
      push_tick(1'b0, $urandom_range(0, 4095), $urandom_range(0, 1), $urandom, $urandom,
                gen_now);
    end
    if ($urandom_range(0, 7) == 0) gen_now = 32'hFFFF_FFFF - $urandom_range(0, 1500);
    n = (g_frz > 0) ? $urandom_range(0, 2) : 0;
    repeat (n) begin
      gen_now += $urandom_range(1, 50);
      push_tick(1'b1, $urandom_range(0, g_frz - 1), $urandom_range(0, 1), $urandom, $urandom,
                gen_now);
    end
    gen_now += $urandom_range(1, 50);
    push_tick(1'b1, pick(g_frz, 4095), $urandom_range(0, 1), $urandom, $urandom, gen_now);
    n = 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        acc = -1;
        target = g_conf + $urandom_range(0, 40);
        while (acc < target && n < 40) begin
          n++;
          if ($urandom_range(0, 9) == 0) begin
            push_miss(1'b0);
            acc = -1;
          end else begin
            step = $urandom_range(1, steps);
            gen_now += step;
            push_tick(1'b1, pick(g_air, 4095), 1'b1, pick(g_alt, 8388607),
                      pick(g_rate, 32767), gen_now);
            acc = (acc < 0) ? 0 : acc + step;
          end
        end
        acc = 0;
        n = 0;
        while (acc < RECOVERY_MS + 200 && n < 15) begin
          n++;
          step = $urandom_range(1, 300);
          gen_now += step;
          acc += step;
          push_tick(1'b1, $urandom_range(0, 4095), $urandom_range(0, 1), $urandom, $urandom,
                    gen_now);
        end
        if ($urandom_range(0, 9) < 6) begin
          gen_now += $urandom_range(1, 50);
          push_tick(1'b0, $urandom_range(0, 4095), $urandom_range(0, 1), $urandom, $urandom,
                    gen_now);
        end
      end
      6, 7, 8: begin
        if (g_abt == 0) begin
          repeat (3) add_noise();
        end else begin
          acc = -1;
          target = ABORT_MS + $urandom_range(0, 40);
          while (acc < target && n < 40) begin
            n++;
            if ($urandom_range(0, 9) == 0) begin
              push_miss(1'b1);
              acc = -1;
            end else begin
              step = $urandom_range(1, 150);
              gen_now += step;
              push_tick(1'b1, pick(0, g_abt - 1), 1'b1, pick(-g_salt, g_salt),
                        pick(-g_srate, g_srate), gen_now);
              acc = (acc < 0) ? 0 : acc + step;
            end
          end
        end
      end
      default: repeat ($urandom_range(1, 4)) add_noise();
    endcase
  endfunction

  function automatic void fill(int count);
    gen_count = 0;
    while (gen_count < count) add_flight();
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.freeze_thr = $urandom_range(0, 4095);
    c.airborne_thr = $urandom_range(0, 4095);
    c.abort_thr = $urandom_range(0, 4095);
    c.min_climb_altitude_mm = ($urandom_range(0, 3) == 0) ? $urandom : pick(-500, 500);
    c.min_climb_rate_mms = ($urandom_range(0, 3) == 0) ? $urandom : pick(-500, 500);
    c.abort_max_altitude_mm = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
    c.abort_max_rate_mms = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
    c.motion_confirm_ms = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1500);
    return c;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [23:0] val, int w);
    logic [23:0] mask;
    mask = (24'd1 << w) - 24'd1;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= (24'($urandom) & ~mask) | (val & mask);
    @(posedge clk);
  endtask

  task automatic set_config(cfg_t c);
    load_gen(c);
    write_reg(REG_FREEZE_THR, 24'(c.freeze_thr), 12);
    write_reg(REG_AIRBORNE_THR, 24'(c.airborne_thr), 12);
    write_reg(REG_ABORT_THR, 24'(c.abort_thr), 12);
    write_reg(REG_MIN_CLB_ALT, 24'(c.min_climb_altitude_mm), 24);
    write_reg(REG_MIN_CLB_RATE, 24'(c.min_climb_rate_mms), 16);
    write_reg(REG_ABORT_ALT, 24'(c.abort_max_altitude_mm), 23);
    write_reg(REG_ABORT_RATE, 24'(c.abort_max_rate_mms), 15);
    write_reg(REG_MOTION_CONF, 24'(c.motion_confirm_ms), 16);
    cfg_we <= 1'b0;
  endtask

  // idle = nothing queued, nothing in flight, every expected transfer seen
  task automatic drain();
    @(negedge clk);
    while (tick_q.size() != 0 || in_valid || phase_exp_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : run_test
    gen_now = 32'd0;
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    load_gen(CFG_DEFAULT);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    push_tick(1'b0, 4095, 1'b1, -8388608, -32768, 32'hFFFF_FFFF);
    push_tick(1'b1, 1149, 1'b1, 8388607, 32767, 100);
    push_tick(1'b1, 1150, 1'b0, 0, 0, 200);
    push_tick(1'b1, 4095, 1'b0, 500, 500, 300);
    push_tick(1'b1, 1300, 1'b1, 200, 100, 1000);
    push_tick(1'b1, 1300, 1'b1, 200, 100, 1299);
    push_tick(1'b1, 1300, 1'b1, 200, 100, 1300);
    push_tick(1'b1, 0, 1'b1, 0, 0, 2299);
    push_tick(1'b1, 0, 1'b1, 0, 0, 2300);
    push_tick(1'b0, 0, 1'b0, 0, 0, 2400);
    push_tick(1'b1, 4095, 1'b1, 0, 0, 3000);
    push_tick(1'b1, 0, 1'b0, 0, 0, 3100);
    push_tick(1'b1, 1099, 1'b1, -100, -100, 5000);
    push_tick(1'b1, 1099, 1'b1, 100, 100, 5499);
    push_tick(1'b1, 1099, 1'b1, 100, 100, 5500);
    push_tick(1'b1, 1150, 1'b1, -8388608, -32768, 6000);
    // motion timer across the time wrap, then a tick inside the recovery window after it
    push_tick(1'b1, 1300, 1'b1, 8388607, 32767, 32'hFFFF_FF00);
    push_tick(1'b1, 1300, 1'b1, 8388607, 32767, 32'h0000_002B);
    push_tick(1'b1, 1300, 1'b1, 8388607, 32767, 32'h0000_002C);
    push_tick(1'b1, 4095, 1'b1, 0, 0, 32'h0000_0400);
    push_tick(1'b0, 0, 1'b0, 0, 0, 32'h0000_0500);
    gen_now = 32'h0000_1000;
    fill(PHASE_ITEMS);
    drain();

    set_config(CFG_FLOOR);
    push_tick(1'b0, 0, 1'b0, 0, 0, gen_now);
    push_tick(1'b1, 0, 1'b1, 0, 0, gen_now + 1);
    push_tick(1'b1, 0, 1'b1, 0, 0, gen_now + 2);
    gen_now += 10;
    fill(PHASE_ITEMS);
    drain();

    // both checks true: abort confirms before motion does
    set_config(CFG_OVERLAP);
    push_tick(1'b0, 0, 1'b0, 0, 0, gen_now);
    push_tick(1'b1, 1500, 1'b1, 0, 0, gen_now + 1);
    push_tick(1'b1, 1500, 1'b1, 0, 0, gen_now + 10);
    push_tick(1'b1, 1500, 1'b1, 0, 0, gen_now + 509);
    push_tick(1'b1, 1500, 1'b1, 0, 0, gen_now + 510);
    gen_now += 600;
    fill(PHASE_ITEMS);
    drain();

    set_config(CFG_CEILING);
    fill(PHASE_ITEMS);
    drain();

    set_config(random_cfg());
    fill(PHASE_ITEMS);
    drain();

    set_config(random_cfg());
    fill(PHASE_ITEMS);
    drain();

    quiet = 1'b1;
    set_config(CFG_DEFAULT);
    fill(PHASE_ITEMS);
    drain();

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: takeoff_phase_detector.f
design/tpd_pkg.sv
design/tpd_cfg.sv
design/tpd_step.sv
design/takeoff_phase_detector.sv
tb/takeoff_phase_detector_tb.sv
